### design/svel_pkg.sv
// ----------------------------------------------------------------------------
// svel_pkg
// shared constants, codes and types of the sparse vector element lookup
// ----------------------------------------------------------------------------
`default_nettype none

package svel_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
  localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int DATA_W      = 32;

  // item operations
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_ZERO  = 3'd1;
  localparam logic [2:0] ST_ORDER = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  // register indexes
  localparam logic REG_DIMENSIONALITY = 1'b0;
  localparam logic REG_BINARY_MODE    = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] dimensionality;
    logic              binary_mode;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              found;
    logic [2:0]        status;
  } result_t;

endpackage

`default_nettype wire

### design/svel_ram.sv
// ----------------------------------------------------------------------------
// svel_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module svel_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### design/svel_engine.sv
// ----------------------------------------------------------------------------
// svel_engine
// entry stores, append checks and the binary search sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module svel_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire svel_pkg::cfg_t                cfg,
  input  wire logic                          item_take,
  input  wire logic [1:0]                    op,
  input  wire logic [svel_pkg::DATA_W-1:0]   dim_index,
  input  wire logic [svel_pkg::DATA_W-1:0]   entry_value,
  output logic                               ready,
  output logic                               res_load,
  output svel_pkg::result_t                  res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_STEP  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;

  logic [1:0]                          state;
  logic [svel_pkg::COUNT_W-1:0]        count;
  logic [svel_pkg::COUNT_W-1:0]        lo;
  logic [svel_pkg::COUNT_W-1:0]        hi;
  logic [svel_pkg::COUNT_W-1:0]        probe;
  logic [svel_pkg::DATA_W-1:0]         key;
  logic [svel_pkg::DATA_W-1:0]         last_index;

  logic [svel_pkg::COUNT_W-1:0]        lo_next;
  logic [svel_pkg::COUNT_W-1:0]        hi_next;
  logic [svel_pkg::COUNT_W-1:0]        mid_next;
  logic [svel_pkg::COUNT_W-1:0]        rd_pos;
  logic                                rd_en;
  logic                                less;
  logic [svel_pkg::DATA_W-1:0]         idx_rdata;
  logic [svel_pkg::DATA_W-1:0]         val_rdata;
  logic [2:0]                          app_status;
  logic                                app_write;
  logic [svel_pkg::DATA_W-1:0]         wr_value;

  // append checks, in priority order
  always_comb begin
    priority if (dim_index >= cfg.dimensionality) begin
      app_status = svel_pkg::ST_RANGE;
    end else if (count != '0 && last_index >= dim_index) begin
      app_status = svel_pkg::ST_ORDER;
    end else if (!cfg.binary_mode && entry_value == '0) begin
      app_status = svel_pkg::ST_ZERO;
    end else if (count >= svel_pkg::COUNT_W'(svel_pkg::MAX_ENTRIES)) begin
      app_status = svel_pkg::ST_FULL;
    end else begin
      app_status = svel_pkg::ST_OK;
    end
  end

  assign app_write = item_take && op == svel_pkg::OP_APPEND && app_status == svel_pkg::ST_OK;
  assign wr_value  = cfg.binary_mode ? svel_pkg::DATA_W'(1) : entry_value;

  // one halving step from the probed index
  assign less     = idx_rdata < key;
  assign lo_next  = less ? probe + 1'b1 : lo;
  assign hi_next  = less ? hi : probe;
  assign mid_next = lo_next + ((hi_next - lo_next) >> 1);

  always_comb begin
    unique case (state)
      S_IDLE:  rd_pos = count >> 1;
      S_STEP:  rd_pos = (lo_next < hi_next) ? mid_next : lo_next;
      default: rd_pos = probe;
    endcase
  end

  assign rd_en = (state == S_IDLE && item_take && op == svel_pkg::OP_QUERY && count != '0)
                 || state == S_STEP;

  svel_ram #(.WIDTH(svel_pkg::DATA_W), .DEPTH(svel_pkg::MAX_ENTRIES)) u_index_ram (
    .clk     (clk),
    .wr_en   (app_write),
    .wr_addr (count[svel_pkg::ENTRY_AW-1:0]),
    .wr_data (dim_index),
    .rd_en   (rd_en),
    .rd_addr (rd_pos[svel_pkg::ENTRY_AW-1:0]),
    .rd_data (idx_rdata)
  );

  svel_ram #(.WIDTH(svel_pkg::DATA_W), .DEPTH(svel_pkg::MAX_ENTRIES)) u_value_ram (
    .clk     (clk),
    .wr_en   (app_write),
    .wr_addr (count[svel_pkg::ENTRY_AW-1:0]),
    .wr_data (wr_value),
    .rd_en   (rd_en),
    .rd_addr (rd_pos[svel_pkg::ENTRY_AW-1:0]),
    .rd_data (val_rdata)
  );

  assign ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      res_load <= 1'b0;
    end else begin
      res_load <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (item_take) begin
            res <= '{read_value: '0, found: 1'b0, status: svel_pkg::ST_OK};
            unique case (op)
              svel_pkg::OP_CLEAR: begin
                count    <= '0;
                res_load <= 1'b1;
              end
              svel_pkg::OP_APPEND: begin
                res.status <= app_status;
                res_load   <= 1'b1;
                if (app_write) begin
                  count      <= count + 1'b1;
                  last_index <= dim_index;
                end
              end
              svel_pkg::OP_QUERY: begin
                key   <= dim_index;
                lo    <= '0;
                hi    <= count;
                probe <= rd_pos;
                if (count == '0) begin
                  res_load <= 1'b1;
                end else begin
                  state <= S_STEP;
                end
              end
              default: begin
                res_load <= 1'b1;
              end
            endcase
          end
        end
        S_STEP: begin
          lo    <= lo_next;
          hi    <= hi_next;
          probe <= rd_pos;
          if (lo_next >= hi_next) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          // probe holds the lower bound position here
          res_load <= 1'b1;
          state    <= S_IDLE;
          if (probe < count && idx_rdata == key) begin
            res.found      <= 1'b1;
            res.read_value <= cfg.binary_mode ? svel_pkg::DATA_W'(1) : val_rdata;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/sparse_vector_element_lookup.sv
// ----------------------------------------------------------------------------
// sparse_vector_element_lookup
// one sparse vector held as sorted (index, value) pairs, with clear, checked
// append and binary search query
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            word
//   in       input      in_valid / in_stall  op, dim_index, entry_value
//   out      output     out_valid / out_stall read_value, found, status
//   cfg      apb slave  psel/penable/pready  dimensionality, binary_mode
//
// clear, append and no-op words are answered from the idle state: the engine
// registers the result with res_load, then the output register raises
// out_valid. a query makes halving probes (at most 11 with 1024 entries), one
// read of the index memory per probe, in the step state, then loads its result
// from the check state. no word goes in while a query runs or res_load is high.
// reset empties the vector and restores the registers; the entry memories are
// not cleared, since only entries below the count are used. a stalled result
// holds the output register and stops further input words.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_vector_element_lookup (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input words
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  op,
  input  wire logic [svel_pkg::DATA_W-1:0] dim_index,
  input  wire logic signed [svel_pkg::DATA_W-1:0] entry_value,
  // result words
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [svel_pkg::DATA_W-1:0] read_value,
  output logic                             found,
  output logic [2:0]                       status,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  svel_pkg::cfg_t    cfg;
  svel_pkg::result_t res;
  logic              res_load;
  logic              engine_ready;
  logic              in_take;
  logic              out_free;

  // configuration registers, one word per 4 bytes
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dimensionality <= '1;
      cfg.binary_mode    <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        svel_pkg::REG_DIMENSIONALITY: cfg.dimensionality <= pwdata;
        svel_pkg::REG_BINARY_MODE:    cfg.binary_mode    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      svel_pkg::REG_DIMENSIONALITY: prdata = cfg.dimensionality;
      svel_pkg::REG_BINARY_MODE:    prdata = {31'd0, cfg.binary_mode};
      default:                      prdata = '0;
    endcase
  end

  // a word goes in only when the engine is idle, no finished result is on
  // its way to the output, and the result register will be free at the next
  // edge
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !(engine_ready && out_free && !res_load);
  assign in_take  = in_valid && !in_stall;

  svel_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_take   (in_take),
    .op          (op),
    .dim_index   (dim_index),
    .entry_value (entry_value),
    .ready       (engine_ready),
    .res_load    (res_load),
    .res         (res)
  );

  // output register: the engine's result is shown from the cycle after it
  // completes until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign read_value = res.read_value;
  assign found      = res.found;
  assign status     = res.status;

endmodule

`default_nettype wire
